// ----- hw/rtl/fsb_pkg.sv -----
package fsb_pkg;

  localparam int FRAME_POINTS = 2048;
  localparam int ADDR_W       = $clog2(FRAME_POINTS);
  localparam int TW_DEPTH     = FRAME_POINTS / 2;
  localparam int TW_AW        = ADDR_W - 1;
  localparam int PASS_W       = $clog2(ADDR_W);
  localparam int MAX_BARS     = 127;
  localparam int BAR_W        = 7;
  localparam int FS_W         = 8;
  localparam int SAMPLE_BITS  = 12;
  localparam int WORD_W       = 16;
  localparam int D_W          = 24;
  localparam int PT_W         = 2 * D_W;
  localparam int TW_W         = 18;
  localparam int PROD_W       = D_W + TW_W;
  localparam int DIFF_W       = PROD_W + 1;
  localparam int ROUND_SH     = 16;
  localparam int T_W          = DIFF_W - ROUND_SH;
  localparam int SUM_W        = T_W + 1;
  localparam int MAG_W        = 24;
  localparam int SQ_W         = 2 * D_W;
  localparam int ROOT_W       = 2 * D_W + 2;
  localparam int DIVN_W       = MAG_W + FS_W;
  localparam int DCNT_W       = $clog2(DIVN_W);
  localparam int FS_RESET     = 180;
  localparam int BC_RESET     = 127;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;

  localparam logic REG_FULL_SCALE = 1'b0;
  localparam logic REG_BAR_COUNT  = 1'b1;

  typedef struct packed {
    logic [FS_W-1:0]  full_scale;
    logic [BAR_W-1:0] bar_count;
  } frame_job_t;

  typedef logic signed [TW_W-1:0] tw_t;
  typedef tw_t tw_rom_t [TW_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] bt;
    v  = x;
    r  = '0;
    bt = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (v >= r + bt) begin
        v = v - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint round_shift(input longint v, input int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic tw_rom_t build_tw(input bit want_sin);
    longint bc [17];
    longint bs [17];
    longint c;
    longint s;
    longint nc;
    longint ns;
    logic [63:0] tmp;
    tw_rom_t rom;
    for (int m = 0; m < 17; m++) begin
      bc[m] = 0;
      bs[m] = 0;
    end
    bc[1] = -(longint'(1) << 30);
    for (int m = 2; m <= ADDR_W; m++) begin
      tmp   = 64'((longint'(1) << 30) + bc[m-1]);
      bc[m] = longint'(isqrt64(tmp << 29));
      tmp   = 64'((longint'(1) << 30) - bc[m-1]);
      bs[m] = longint'(isqrt64(tmp << 29));
    end
    for (int k = 0; k < TW_DEPTH; k++) begin
      c = longint'(1) << 30;
      s = 0;
      for (int b = 0; b + 2 <= ADDR_W; b++) begin
        if (((k >> b) & 1) != 0) begin
          nc = round_shift(c * bc[ADDR_W-b] - s * bs[ADDR_W-b], 30);
          ns = round_shift(c * bs[ADDR_W-b] + s * bc[ADDR_W-b], 30);
          c  = nc;
          s  = ns;
        end
      end
      if (want_sin) begin
        rom[k] = TW_W'(-round_shift(s, 14));
      end else begin
        rom[k] = TW_W'(round_shift(c, 14));
      end
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_COS  = build_tw(1'b0);
  localparam tw_rom_t TW_NSIN = build_tw(1'b1);

  function automatic logic [ADDR_W-1:0] bit_reverse(input logic [ADDR_W-1:0] i);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) begin
      r[ADDR_W-1-b] = i[b];
    end
    return r;
  endfunction

  function automatic logic signed [D_W-1:0] sat_d(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'((longint'(1) << (D_W - 1)) - 1);
    lo = -SUM_W'(longint'(1) << (D_W - 1));
    if (v > hi) begin
      return hi[D_W-1:0];
    end else if (v < lo) begin
      return lo[D_W-1:0];
    end
    return v[D_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/fsb_point_ram.sv -----
module fsb_point_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [DATA_W-1:0] rd_data_a,
  output logic [DATA_W-1:0] rd_data_b
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- hw/rtl/fsb_front.sv -----
module fsb_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fsb_pkg::WORD_W-1:0]        adc_word,
  input  logic [fsb_pkg::FS_W-1:0]          full_scale,
  input  logic [fsb_pkg::BAR_W-1:0]         bar_count,
  input  logic                              job_full,
  output logic                              job_push,
  output fsb_pkg::frame_job_t               job_data,
  input  logic                              frame_release,
  output logic                              frame_held,
  output logic                              wr_en,
  output logic [fsb_pkg::ADDR_W-1:0]        wr_addr,
  output logic [fsb_pkg::PT_W-1:0]          wr_data
);

  logic [fsb_pkg::ADDR_W-1:0]        sample_count;
  logic                              accept;
  logic                              last_sample;
  logic signed [fsb_pkg::SAMPLE_BITS:0] centred;

  assign in_stall    = frame_held | job_full;
  assign accept      = in_valid & ~in_stall;
  assign last_sample = (sample_count == fsb_pkg::ADDR_W'(fsb_pkg::FRAME_POINTS - 1));

  assign centred = $signed({1'b0, adc_word[fsb_pkg::SAMPLE_BITS-1:0]})
                 - $signed((fsb_pkg::SAMPLE_BITS+1)'(1 << (fsb_pkg::SAMPLE_BITS - 1)));

  assign wr_en   = accept;
  assign wr_addr = fsb_pkg::bit_reverse(sample_count);
  assign wr_data = {fsb_pkg::D_W'(centred), fsb_pkg::D_W'(0)};

  assign job_push            = accept & last_sample;
  assign job_data.full_scale = full_scale;
  assign job_data.bar_count  = (bar_count == '0) ? fsb_pkg::BAR_W'(1) : bar_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      frame_held   <= 1'b0;
    end else begin
      if (frame_release) begin
        frame_held <= 1'b0;
      end
      if (accept) begin
        if (last_sample) begin
          sample_count <= '0;
          frame_held   <= 1'b1;
        end else begin
          sample_count <= sample_count + 1'b1;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/fsb_queue.sv -----
module fsb_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  fsb_pkg::frame_job_t push_data,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output fsb_pkg::frame_job_t head
);

  fsb_pkg::frame_job_t entries [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Frame request pushed into a full queue.");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Frame request popped from an empty queue.");
`endif

endmodule

// ----- hw/rtl/fsb_back.sv -----
module fsb_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        job_empty,
  input  fsb_pkg::frame_job_t         job_head,
  output logic                        job_pop,
  output logic                        frame_release,
  output logic [fsb_pkg::ADDR_W-1:0]  rd_addr_a,
  output logic [fsb_pkg::ADDR_W-1:0]  rd_addr_b,
  input  logic [fsb_pkg::PT_W-1:0]    rd_data_a,
  input  logic [fsb_pkg::PT_W-1:0]    rd_data_b,
  output logic                        wr_en,
  output logic [fsb_pkg::ADDR_W-1:0]  wr_addr,
  output logic [fsb_pkg::PT_W-1:0]    wr_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [fsb_pkg::BAR_W-1:0]   bar_index,
  output logic [fsb_pkg::FS_W-1:0]    height_first,
  output logic [fsb_pkg::FS_W-1:0]    height_second,
  output logic                        second_valid,
  output logic                        frame_last
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_WA, ST_BF_WB,
    ST_MAG_RD, ST_MAG_SQ, ST_MAG_ADD, ST_SQRT, ST_MAG_WR,
    ST_BAR_RD, ST_DIV_LOAD, ST_DIV, ST_DIV_END, ST_OUT
  } state_t;

  state_t                              state;
  fsb_pkg::frame_job_t                 job;
  logic [fsb_pkg::PASS_W-1:0]          pass;
  logic [fsb_pkg::TW_AW-1:0]           bfly;
  logic [fsb_pkg::BAR_W-1:0]           k;
  logic [fsb_pkg::BAR_W-1:0]           pair_first;
  logic                                half;
  logic signed [fsb_pkg::D_W-1:0]      a_re;
  logic signed [fsb_pkg::D_W-1:0]      a_im;
  logic signed [fsb_pkg::PROD_W-1:0]   p_rr;
  logic signed [fsb_pkg::PROD_W-1:0]   p_ii;
  logic signed [fsb_pkg::PROD_W-1:0]   p_ri;
  logic signed [fsb_pkg::PROD_W-1:0]   p_ir;
  logic [fsb_pkg::PT_W-1:0]            new_a;
  logic [fsb_pkg::PT_W-1:0]            new_b;
  logic [fsb_pkg::SQ_W-1:0]            sq_re;
  logic [fsb_pkg::SQ_W-1:0]            sq_im;
  logic [fsb_pkg::ROOT_W-1:0]          root_v;
  logic [fsb_pkg::ROOT_W-1:0]          root_r;
  logic [fsb_pkg::ROOT_W-1:0]          root_bit;
  logic [fsb_pkg::MAG_W-1:0]           peak;
  logic [fsb_pkg::DIVN_W-1:0]          div_n;
  logic [fsb_pkg::DIVN_W-1:0]          div_q;
  logic [fsb_pkg::MAG_W-1:0]           div_rem;
  logic [fsb_pkg::DCNT_W-1:0]          div_cnt;
  logic [fsb_pkg::FS_W-1:0]            h_first;
  logic [fsb_pkg::FS_W-1:0]            h_second;
  logic signed [fsb_pkg::TW_W-1:0]     tw_wr;
  logic signed [fsb_pkg::TW_W-1:0]     tw_wi;
  logic [fsb_pkg::MAG_W-1:0]           mag_mem [fsb_pkg::MAX_BARS];
  logic [fsb_pkg::MAG_W-1:0]           mag_q;

  logic [fsb_pkg::TW_AW-1:0]           low_mask;
  logic [fsb_pkg::TW_AW-1:0]           bf_j;
  logic [fsb_pkg::ADDR_W-1:0]          addr_a;
  logic [fsb_pkg::ADDR_W-1:0]          addr_b;
  logic [fsb_pkg::TW_AW-1:0]           tw_idx;
  logic signed [fsb_pkg::D_W-1:0]      b_re;
  logic signed [fsb_pkg::D_W-1:0]      b_im;
  logic signed [fsb_pkg::DIFF_W-1:0]   t_re_full;
  logic signed [fsb_pkg::DIFF_W-1:0]   t_im_full;
  logic signed [fsb_pkg::T_W-1:0]      t_re;
  logic signed [fsb_pkg::T_W-1:0]      t_im;
  logic [fsb_pkg::ROOT_W-1:0]          root_try;
  logic [fsb_pkg::MAG_W:0]             rem_sh;
  logic                                rem_ge;
  logic [fsb_pkg::FS_W-1:0]            h_clamped;
  logic [fsb_pkg::MAG_W-1:0]           mag_now;
  logic                                pass_last;
  logic                                bfly_last;
  logic                                bar_last;
  logic                                out_free;

  assign low_mask  = (fsb_pkg::TW_AW'(1) << pass) - 1'b1;
  assign bf_j      = bfly & low_mask;
  assign addr_a    = {bfly & ~low_mask, 1'b0} | {1'b0, bf_j};
  assign addr_b    = addr_a | (fsb_pkg::ADDR_W'(1) << pass);
  assign tw_idx    = bf_j << (fsb_pkg::PASS_W'(fsb_pkg::ADDR_W - 1) - pass);
  assign pass_last = (pass == fsb_pkg::PASS_W'(fsb_pkg::ADDR_W - 1));
  assign bfly_last = (bfly == fsb_pkg::TW_AW'(fsb_pkg::TW_DEPTH - 1));

  assign b_re = rd_data_b[fsb_pkg::PT_W-1:fsb_pkg::D_W];
  assign b_im = rd_data_b[fsb_pkg::D_W-1:0];

  assign t_re_full = fsb_pkg::DIFF_W'(p_rr) - fsb_pkg::DIFF_W'(p_ii)
                   + fsb_pkg::DIFF_W'(1 << (fsb_pkg::ROUND_SH - 1));
  assign t_im_full = fsb_pkg::DIFF_W'(p_ri) + fsb_pkg::DIFF_W'(p_ir)
                   + fsb_pkg::DIFF_W'(1 << (fsb_pkg::ROUND_SH - 1));
  assign t_re      = t_re_full[fsb_pkg::DIFF_W-1:fsb_pkg::ROUND_SH];
  assign t_im      = t_im_full[fsb_pkg::DIFF_W-1:fsb_pkg::ROUND_SH];

  assign root_try  = root_r + root_bit;
  assign mag_now   = root_r[fsb_pkg::MAG_W-1:0];

  assign rem_sh    = {div_rem, div_n[fsb_pkg::DIVN_W-1]};
  assign rem_ge    = (rem_sh >= {1'b0, peak});
  assign h_clamped = (peak == '0) ? '0 :
                     (div_q > fsb_pkg::DIVN_W'(job.full_scale)) ? job.full_scale :
                     div_q[fsb_pkg::FS_W-1:0];

  assign bar_last  = ({1'b0, k} + 1'b1) >= {1'b0, job.bar_count};
  assign out_free  = ~out_valid | ~out_stall;

  assign job_pop   = (state == ST_IDLE) & ~job_empty;
  assign rd_addr_a = (state == ST_MAG_RD) ? fsb_pkg::ADDR_W'(k) + 1'b1 : addr_a;
  assign rd_addr_b = addr_b;
  assign wr_en     = (state == ST_BF_WA) | (state == ST_BF_WB);
  assign wr_addr   = (state == ST_BF_WB) ? addr_b : addr_a;
  assign wr_data   = (state == ST_BF_WB) ? new_b : new_a;

  always_ff @(posedge clk) begin
    tw_wr <= fsb_pkg::TW_COS[tw_idx];
    tw_wi <= fsb_pkg::TW_NSIN[tw_idx];
    if (state == ST_MAG_WR) begin
      mag_mem[k] <= mag_now;
    end
    mag_q <= mag_mem[k];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      frame_release <= 1'b0;
      pass          <= '0;
      bfly          <= '0;
      k             <= '0;
      half          <= 1'b0;
      peak          <= '0;
    end else begin
      frame_release <= (state == ST_MAG_WR) && bar_last;
      if ((state == ST_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            job   <= job_head;
            pass  <= '0;
            bfly  <= '0;
            state <= ST_BF_RD;
          end
        end
        ST_BF_RD: begin
          state <= ST_BF_MUL;
        end
        ST_BF_MUL: begin
          a_re  <= rd_data_a[fsb_pkg::PT_W-1:fsb_pkg::D_W];
          a_im  <= rd_data_a[fsb_pkg::D_W-1:0];
          p_rr  <= b_re * tw_wr;
          p_ii  <= b_im * tw_wi;
          p_ri  <= b_re * tw_wi;
          p_ir  <= b_im * tw_wr;
          state <= ST_BF_SUM;
        end
        ST_BF_SUM: begin
          new_a <= {fsb_pkg::sat_d(fsb_pkg::SUM_W'(a_re) + fsb_pkg::SUM_W'(t_re)),
                    fsb_pkg::sat_d(fsb_pkg::SUM_W'(a_im) + fsb_pkg::SUM_W'(t_im))};
          new_b <= {fsb_pkg::sat_d(fsb_pkg::SUM_W'(a_re) - fsb_pkg::SUM_W'(t_re)),
                    fsb_pkg::sat_d(fsb_pkg::SUM_W'(a_im) - fsb_pkg::SUM_W'(t_im))};
          state <= ST_BF_WA;
        end
        ST_BF_WA: begin
          state <= ST_BF_WB;
        end
        ST_BF_WB: begin
          bfly <= bfly + 1'b1;
          if (bfly_last) begin
            if (pass_last) begin
              k     <= '0;
              peak  <= '0;
              state <= ST_MAG_RD;
            end else begin
              pass  <= pass + 1'b1;
              state <= ST_BF_RD;
            end
          end else begin
            state <= ST_BF_RD;
          end
        end
        ST_MAG_RD: begin
          state <= ST_MAG_SQ;
        end
        ST_MAG_SQ: begin
          sq_re <= fsb_pkg::SQ_W'(
            $signed(rd_data_a[fsb_pkg::PT_W-1:fsb_pkg::D_W]) *
            $signed(rd_data_a[fsb_pkg::PT_W-1:fsb_pkg::D_W]));
          sq_im <= fsb_pkg::SQ_W'(
            $signed(rd_data_a[fsb_pkg::D_W-1:0]) * $signed(rd_data_a[fsb_pkg::D_W-1:0]));
          state <= ST_MAG_ADD;
        end
        ST_MAG_ADD: begin
          root_v   <= fsb_pkg::ROOT_W'(sq_re) + fsb_pkg::ROOT_W'(sq_im);
          root_r   <= '0;
          root_bit <= fsb_pkg::ROOT_W'(1) << (fsb_pkg::ROOT_W - 2);
          state    <= ST_SQRT;
        end
        ST_SQRT: begin
          if (root_v >= root_try) begin
            root_v <= root_v - root_try;
            root_r <= (root_r >> 1) + root_bit;
          end else begin
            root_r <= root_r >> 1;
          end
          root_bit <= root_bit >> 2;
          if (root_bit[0]) begin
            state <= ST_MAG_WR;
          end
        end
        ST_MAG_WR: begin
          if (mag_now > peak) begin
            peak <= mag_now;
          end
          if (bar_last) begin
            k     <= '0;
            half  <= 1'b0;
            state <= ST_BAR_RD;
          end else begin
            k     <= k + 1'b1;
            state <= ST_MAG_RD;
          end
        end
        ST_BAR_RD: begin
          state <= ST_DIV_LOAD;
        end
        ST_DIV_LOAD: begin
          div_n   <= fsb_pkg::DIVN_W'(mag_q * job.full_scale);
          div_rem <= '0;
          div_q   <= '0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_ge) begin
            div_rem <= fsb_pkg::MAG_W'(rem_sh - {1'b0, peak});
          end else begin
            div_rem <= rem_sh[fsb_pkg::MAG_W-1:0];
          end
          div_q   <= {div_q[fsb_pkg::DIVN_W-2:0], rem_ge};
          div_n   <= div_n << 1;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == fsb_pkg::DCNT_W'(fsb_pkg::DIVN_W - 1)) begin
            state <= ST_DIV_END;
          end
        end
        ST_DIV_END: begin
          if (!half) begin
            h_first    <= h_clamped;
            pair_first <= k;
            if (bar_last) begin
              half  <= 1'b0;
              state <= ST_OUT;
            end else begin
              k     <= k + 1'b1;
              half  <= 1'b1;
              state <= ST_BAR_RD;
            end
          end else begin
            h_second <= h_clamped;
            state    <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            bar_index     <= pair_first;
            height_first  <= h_first;
            height_second <= half ? h_second : '0;
            second_valid  <= half;
            frame_last    <= bar_last;
            half          <= 1'b0;
            if (bar_last) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= ST_BAR_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_peak_covers: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAG_WR) |=> (peak >= $past(mag_now)))
    else $error("Peak magnitude fell below a stored magnitude.");
  a_root_floor: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAG_WR) |-> ((root_r * root_r) <= ((sq_re + sq_im) & {fsb_pkg::ROOT_W{1'b1}})))
    else $error("Square root result exceeds the floor root.");
  a_height_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_END) |-> (h_clamped <= job.full_scale))
    else $error("Bar height above full scale.");
`endif

endmodule

// ----- hw/rtl/fft_spectrum_bar_engine.sv -----
// Spectrum bar engine. Converter words arrive on the input channel (in_valid,
// in_stall, adc_word), one request per sample; the low 12 bits are used.
// Every 2048 samples complete a frame, which is handed to the transform side
// through a two-entry request queue. A single butterfly unit then runs 11
// passes of 1024 butterflies, each stepping through read, multiply, sum,
// write A and write B, followed by the magnitudes of the selected bins, where
// one bit-serial square root step per cycle forms each root. The input stalls
// from the end of a frame until the magnitudes are done.
// Bar heights then come out on the output channel (out_valid, out_stall,
// bar_index, height_first, height_second, second_valid, frame_last), two
// bars per request, one in the last when the bar count is odd; heights come
// from a 32-step divider. When the receiver stalls, the current request
// holds in the output register and the engine waits; sample gathering for
// the next frame goes on. Reset clears the sample counter, the queue and
// all sequencing state and sets full scale to 180 and bar count to 127.
// Registers are written over the APB port at byte addresses 0 and 4; the
// user must write them while the block is idle; the block does not enforce it.
module fft_spectrum_bar_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fsb_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [fsb_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [fsb_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [fsb_pkg::WORD_W-1:0]        adc_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fsb_pkg::BAR_W-1:0]         bar_index,
  output logic [fsb_pkg::FS_W-1:0]          height_first,
  output logic [fsb_pkg::FS_W-1:0]          height_second,
  output logic                              second_valid,
  output logic                              frame_last
);

  logic [fsb_pkg::FS_W-1:0]   bar_full_scale;
  logic [fsb_pkg::BAR_W-1:0]  bar_count;
  logic                       cfg_write;

  fsb_pkg::frame_job_t        job_data;
  fsb_pkg::frame_job_t        job_head;
  logic                       job_push;
  logic                       job_pop;
  logic                       job_full;
  logic                       job_empty;
  logic                       frame_release;
  logic                       frame_held;

  logic                       f_wr_en;
  logic [fsb_pkg::ADDR_W-1:0] f_wr_addr;
  logic [fsb_pkg::PT_W-1:0]   f_wr_data;
  logic                       b_wr_en;
  logic [fsb_pkg::ADDR_W-1:0] b_wr_addr;
  logic [fsb_pkg::PT_W-1:0]   b_wr_data;
  logic [fsb_pkg::ADDR_W-1:0] rd_addr_a;
  logic [fsb_pkg::ADDR_W-1:0] rd_addr_b;
  logic [fsb_pkg::PT_W-1:0]   rd_data_a;
  logic [fsb_pkg::PT_W-1:0]   rd_data_b;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == fsb_pkg::REG_BAR_COUNT) ?
                     fsb_pkg::CFG_DATA_W'(bar_count) : fsb_pkg::CFG_DATA_W'(bar_full_scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_full_scale <= fsb_pkg::FS_W'(fsb_pkg::FS_RESET);
      bar_count      <= fsb_pkg::BAR_W'(fsb_pkg::BC_RESET);
    end else if (cfg_write) begin
      case (paddr[2])
        fsb_pkg::REG_FULL_SCALE: bar_full_scale <= pwdata[fsb_pkg::FS_W-1:0];
        fsb_pkg::REG_BAR_COUNT:  bar_count      <= pwdata[fsb_pkg::BAR_W-1:0];
        default: ;
      endcase
    end
  end

  fsb_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .adc_word      (adc_word),
    .full_scale    (bar_full_scale),
    .bar_count     (bar_count),
    .job_full      (job_full),
    .job_push      (job_push),
    .job_data      (job_data),
    .frame_release (frame_release),
    .frame_held    (frame_held),
    .wr_en         (f_wr_en),
    .wr_addr       (f_wr_addr),
    .wr_data       (f_wr_data)
  );

  fsb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job_data),
    .full      (job_full),
    .pop       (job_pop),
    .empty     (job_empty),
    .head      (job_head)
  );

  fsb_point_ram #(
    .ADDR_W (fsb_pkg::ADDR_W),
    .DATA_W (fsb_pkg::PT_W)
  ) u_points (
    .clk       (clk),
    .wr_en     (f_wr_en | b_wr_en),
    .wr_addr   (b_wr_en ? b_wr_addr : f_wr_addr),
    .wr_data   (b_wr_en ? b_wr_data : f_wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  fsb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_empty     (job_empty),
    .job_head      (job_head),
    .job_pop       (job_pop),
    .frame_release (frame_release),
    .rd_addr_a     (rd_addr_a),
    .rd_addr_b     (rd_addr_b),
    .rd_data_a     (rd_data_a),
    .rd_data_b     (rd_data_b),
    .wr_en         (b_wr_en),
    .wr_addr       (b_wr_addr),
    .wr_data       (b_wr_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bar_index     (bar_index),
    .height_first  (height_first),
    .height_second (height_second),
    .second_valid  (second_valid),
    .frame_last    (frame_last)
  );

`ifndef NO_ASSERTIONS
  a_store_owned: assert property (@(posedge clk) disable iff (rst)
    b_wr_en |-> (frame_held && !f_wr_en))
    else $error("Transform wrote the point store while samples were being gathered.");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;

  localparam int FRAME_LEN = 2048;
  localparam int LOG_LEN = 11;
  localparam int NUM_TW = FRAME_LEN / 2;
  localparam int STALL_LIMIT = 500000;
  localparam int HOLD_CYCLES = 150000;
  localparam int SETTLE_CYCLES = 200;

  typedef enum int {FRAME_DIRECTED, FRAME_TONE, FRAME_FLAT} frame_kind_t;

  typedef struct {
    logic [fsb_pkg::BAR_W-1:0] idx;
    logic [fsb_pkg::FS_W-1:0] h1;
    logic [fsb_pkg::FS_W-1:0] h2;
    logic sv;
    logic last;
  } bar_pair_t;

  function automatic longint shift_round(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint sat24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  class bar_scoreboard;
    int unsigned full_scale;
    int unsigned bar_count;
    longint pt_re[FRAME_LEN];
    longint pt_im[FRAME_LEN];
    int fill;
    longint cos_q16[NUM_TW];
    longint sin_q16[NUM_TW];
    bar_pair_t pending[$];
    int errors;

    function new();
      longint hc[17];
      longint hs[17];
      longint c;
      longint s;
      longint nc;
      full_scale = fsb_pkg::FS_RESET;
      bar_count = fsb_pkg::BC_RESET;
      fill = 0;
      errors = 0;
      hc[1] = -(longint'(1) << 30);
      hs[1] = 0;
      for (int m = 2; m <= LOG_LEN; m++) begin
        hc[m] = longint'(floor_sqrt(64'((longint'(1) << 30) + hc[m-1]) << 29));
        hs[m] = longint'(floor_sqrt(64'((longint'(1) << 30) - hc[m-1]) << 29));
      end
      for (int k = 0; k < NUM_TW; k++) begin
        c = longint'(1) << 30;
        s = 0;
        for (int b = 0; b + 2 <= LOG_LEN; b++) begin
          if ((k >> b) & 1) begin
            nc = shift_round(c * hc[LOG_LEN-b] - s * hs[LOG_LEN-b], 30);
            s = shift_round(c * hs[LOG_LEN-b] + s * hc[LOG_LEN-b], 30);
            c = nc;
          end
        end
        cos_q16[k] = shift_round(c, 14);
        sin_q16[k] = shift_round(s, 14);
      end
    endfunction

    function void transform();
      int r;
      int step;
      longint t;
      longint wr;
      longint wi;
      longint tr;
      longint ti;
      longint ar;
      longint ai;
      for (int i = 0; i < FRAME_LEN; i++) begin
        r = 0;
        for (int b = 0; b < LOG_LEN; b++) r |= ((i >> b) & 1) << (LOG_LEN - 1 - b);
        if (r > i) begin
          t = pt_re[i]; pt_re[i] = pt_re[r]; pt_re[r] = t;
          t = pt_im[i]; pt_im[i] = pt_im[r]; pt_im[r] = t;
        end
      end
      for (int h = 1; h < FRAME_LEN; h = h * 2) begin
        step = FRAME_LEN / (2 * h);
        for (int g = 0; g < FRAME_LEN; g += 2 * h) begin
          for (int j = 0; j < h; j++) begin
            wr = cos_q16[j * step];
            wi = -sin_q16[j * step];
            tr = shift_round(pt_re[g+j+h] * wr - pt_im[g+j+h] * wi, 16);
            ti = shift_round(pt_re[g+j+h] * wi + pt_im[g+j+h] * wr, 16);
            ar = pt_re[g+j];
            ai = pt_im[g+j];
            pt_re[g+j] = sat24(ar + tr);
            pt_im[g+j] = sat24(ai + ti);
            pt_re[g+j+h] = sat24(ar - tr);
            pt_im[g+j+h] = sat24(ai - ti);
          end
        end
      end
    endfunction

    function int unsigned height(int unsigned mag, int unsigned peak);
      longint unsigned hgt;
      if (peak == 0) return 0;
      hgt = longint'(mag) * full_scale / peak;
      if (hgt > full_scale) hgt = full_scale;
      return int'(hgt);
    endfunction

    function void note_sample(logic [fsb_pkg::WORD_W-1:0] word);
      int unsigned bars;
      int unsigned peak;
      int unsigned mags[fsb_pkg::MAX_BARS];
      int unsigned pairs;
      bar_pair_t p;
      pt_re[fill] = longint'(word[fsb_pkg::SAMPLE_BITS-1:0]) - (1 << (fsb_pkg::SAMPLE_BITS - 1));
      pt_im[fill] = 0;
      fill++;
      if (fill < FRAME_LEN) return;
      fill = 0;
      transform();
      bars = bar_count;
      if (bars == 0) bars = 1;
      if (bars > fsb_pkg::MAX_BARS) bars = fsb_pkg::MAX_BARS;
      peak = 0;
      for (int k = 0; k < bars; k++) begin
        mags[k] = int'(floor_sqrt(64'(pt_re[k+1] * pt_re[k+1] + pt_im[k+1] * pt_im[k+1]))
                       & 64'hFFFFFF);
        if (mags[k] > peak) peak = mags[k];
      end
      pairs = (bars + 1) / 2;
      for (int k = 0; k < pairs; k++) begin
        p.idx = fsb_pkg::BAR_W'(2 * k);
        p.h1 = fsb_pkg::FS_W'(height(mags[2*k], peak));
        p.sv = (2 * k + 1) < bars;
        p.h2 = p.sv ? fsb_pkg::FS_W'(height(mags[2*k+1], peak)) : '0;
        p.last = (k + 1 == pairs);
        pending.push_back(p);
      end
    endfunction

    function void check_pair(bar_pair_t got);
      bar_pair_t want;
      if (pending.size() == 0) begin
        $error("bar pair at index %0d with nothing expected", got.idx);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.idx !== want.idx) begin
        $error("bar_index expected %0d got %0d", want.idx, got.idx);
        errors++;
      end
      if (got.h1 !== want.h1) begin
        $error("height_first expected %0d got %0d", want.h1, got.h1);
        errors++;
      end
      if (got.h2 !== want.h2) begin
        $error("height_second expected %0d got %0d", want.h2, got.h2);
        errors++;
      end
      if (got.sv !== want.sv) begin
        $error("second_valid expected %0d got %0d", want.sv, got.sv);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("frame_last expected %0d got %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fsb_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [fsb_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [fsb_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [fsb_pkg::WORD_W-1:0] adc_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [fsb_pkg::BAR_W-1:0] bar_index;
  logic [fsb_pkg::FS_W-1:0] height_first;
  logic [fsb_pkg::FS_W-1:0] height_second;
  logic second_valid;
  logic frame_last;

  int tx_idle_pct = 37;
  int rx_idle_pct = 58;
  logic hold_off = 1'b0;
  int quiet_cycles = 0;
  bar_scoreboard sb = new();

  fft_spectrum_bar_engine uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= hold_off || (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk) begin
    bar_pair_t got;
    if (!rst && out_valid && !out_stall) begin
      got.idx = bar_index;
      got.h1 = height_first;
      got.h2 = height_second;
      got.sv = second_valid;
      got.last = frame_last;
      sb.check_pair(got);
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("FAIL fft_spectrum_bar_engine");
    $finish;
  end

  task automatic write_reg(logic reg_sel, logic [fsb_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == fsb_pkg::REG_FULL_SCALE) sb.full_scale = value & 32'hFF;
    else sb.bar_count = value & 32'h7F;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_word(logic [fsb_pkg::WORD_W-1:0] word);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    adc_word <= word;
    do @(posedge clk); while (in_stall);
    sb.note_sample(word);
    @(negedge clk);
  endtask

  task automatic send_frame(frame_kind_t kind);
    logic [fsb_pkg::WORD_W-1:0] edges[12] = '{16'h0000, 16'hFFFF, 16'h0FFF, 16'hF000,
                                               16'h0800, 16'h07FF, 16'h1000, 16'hAAAA,
                                               16'h5555, 16'h8001, 16'h7FFE, 16'h0001};
    int period1;
    int period2;
    int amp1;
    int amp2;
    int noise;
    int v;
    logic [fsb_pkg::WORD_W-1:0] flat;
    period1 = $urandom_range(40, 2);
    period2 = $urandom_range(300, 3);
    amp1 = $urandom_range(1500, 1);
    amp2 = $urandom_range(400);
    noise = $urandom_range(200);
    flat = fsb_pkg::WORD_W'($urandom);
    for (int i = 0; i < FRAME_LEN; i++) begin
      if (kind == FRAME_FLAT) begin
        send_word({4'($urandom), flat[fsb_pkg::SAMPLE_BITS-1:0]});
      end else if (kind == FRAME_DIRECTED && i < 12) begin
        send_word(edges[i]);
      end else begin
        v = 2048 + (((i / period1) % 2) ? amp1 : -amp1) + (((i / period2) % 2) ? amp2 : -amp2)
            + $urandom_range(2 * noise) - noise;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        send_word({4'($urandom), 12'(v)});
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_frame(FRAME_DIRECTED);
    drain();
    write_reg(fsb_pkg::REG_FULL_SCALE, 32'hFFFF_FF7F & 32'h0000_01FF);
    write_reg(fsb_pkg::REG_BAR_COUNT, 32'd126);
    send_frame(FRAME_TONE);
    drain();

    tx_idle_pct = 58;
    rx_idle_pct = 37;
    write_reg(fsb_pkg::REG_FULL_SCALE, 32'd1);
    write_reg(fsb_pkg::REG_BAR_COUNT, 32'd1);
    send_frame(FRAME_FLAT);
    drain();
    write_reg(fsb_pkg::REG_FULL_SCALE, 32'd0);
    write_reg(fsb_pkg::REG_BAR_COUNT, 32'h0000_0F80);
    send_frame(FRAME_TONE);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(fsb_pkg::REG_FULL_SCALE, 32'd255);
    write_reg(fsb_pkg::REG_BAR_COUNT, 32'd127);
    fork
      begin
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    send_frame(FRAME_TONE);
    send_frame(FRAME_TONE);
    drain();
    write_reg(fsb_pkg::REG_FULL_SCALE, 32'd93);
    write_reg(fsb_pkg::REG_BAR_COUNT, 32'd63);
    send_frame(FRAME_TONE);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS fft_spectrum_bar_engine");
    end else begin
      $display("FAIL fft_spectrum_bar_engine");
    end
    $finish;
  end
endmodule
